FILE: rtl/core/hinted_block_bitmap_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef HINTED_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define HINTED_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define HBBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hbba assertion failed");
// Checked on every clock edge, reset included.
`define HBBA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("hbba assertion failed");
`else
`define HBBA_ASSERT(lbl, clk, rst, prop)
`define HBBA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/hbba_pkg.sv
// Types, constants and helper functions of the block bitmap allocator.
package hbba_pkg;

   localparam int MAX_BLOCKS = 4096;
   localparam int WORD_BITS  = 64;
   localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
   localparam int BLK_W      = 12;
   localparam int SIZE_W     = 13;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WADDR_W    = $clog2(MAP_WORDS);
   localparam int WCNT_W     = WADDR_W + 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_MARK  = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUME_BLOCKS = 1'b0,
      CSR_READ_ONLY     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_RMW,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;       // clamped to MAX_BLOCKS
      logic              read_only;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             success;
      logic [BLK_W-1:0] block;
   } result_type;

   // bits strictly below position b
   function automatic word_type mask_lt(logic [BIT_W-1:0] b);
      return (word_type'(1) << b) - word_type'(1);
   endfunction

   // lowest set bit
   function automatic logic [BIT_W-1:0] first_one(word_type w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) pos = BIT_W'(i);
      end
      return pos;
   endfunction

endpackage

FILE: rtl/core/hinted_block_bitmap_allocator.sv
// Top level of the hinted next-fit block bitmap allocator.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/req_ready, req_cmd, req_block_index | in
//  rsp     | rsp_valid/rsp_ready, rsp_success, rsp_allocated_block | out
//  csr     | csr_we, csr_index, csr_wdata            | in
//
// The used map sits in a 64 x 64-bit RAM; one item is worked at a time.
// Mark, free and query pass through read, modify/write and respond states.
// Out-of-range mark/free/query indices and allocates that cannot succeed go
// straight to respond. Allocate reads one map word per cycle, up to
// ceil(size/64)+1 words with the wrap back to the start word; after the
// result goes out the sequencer returns to idle and takes the next item.
// Reset is synchronous; per-word valid flops make unwritten words read as free,
// so there is no clearing pass. A new item is taken while a result waits in the
// output register; a stalled result holds the sequencer in its last state.
module hinted_block_bitmap_allocator
   import hbba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [BLK_W-1:0]      req_block_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_success,
   output logic [BLK_W-1:0]      rsp_allocated_block,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SIZE_W-1:0] volume_blocks_ff;
   logic              read_only_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_success_ff;
   logic [BLK_W-1:0]  rsp_block_ff;

   cfg_type           cfg;
   result_type        res;
   logic              res_room;

   logic              ram_re;
   logic [WADDR_W-1:0] ram_raddr;
   logic              ram_we;
   logic [WADDR_W-1:0] ram_waddr;
   word_type          ram_wdata;
   word_type          ram_rdata;

   // volume sizes past the map act as a full map
   assign cfg.size = (volume_blocks_ff > SIZE_W'(MAX_BLOCKS)) ? SIZE_W'(MAX_BLOCKS)
                                                               : volume_blocks_ff;
   assign cfg.read_only = read_only_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_blocks_ff <= SIZE_W'(MAX_BLOCKS);
         read_only_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_VOLUME_BLOCKS: volume_blocks_ff <= csr_wdata[SIZE_W-1:0];
            CSR_READ_ONLY:     read_only_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // output register: loads when empty or being drained
   assign res_room     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (res.valid && res_room) ? 1'b1
                       : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (res.valid && res_room) begin
         rsp_success_ff <= res.success;
         rsp_block_ff   <= res.block;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_allocated_block = rsp_block_ff;

   hbba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   hbba_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_cmd         (req_cmd),
      .req_block_index (req_block_index),
      .req_ready       (req_ready),
      .res             (res),
      .res_room        (res_room),
      .ram_re          (ram_re),
      .ram_raddr       (ram_raddr),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_rdata       (ram_rdata)
   );

endmodule

FILE: rtl/core/hbba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hbba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/hbba_ctrl.sv
// Command sequencer: word scan, read-modify-write and word valid bits.
`include "hinted_block_bitmap_allocator_assert.svh"

module hbba_ctrl
   import hbba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   input  logic [1:0]          req_cmd,
   input  logic [BLK_W-1:0]    req_block_index,
   output logic                req_ready,
   output result_type          res,
   input  logic                res_room,
   output logic                ram_re,
   output logic [WADDR_W-1:0]  ram_raddr,
   output logic                ram_we,
   output logic [WADDR_W-1:0]  ram_waddr,
   output word_type            ram_wdata,
   input  word_type            ram_rdata
);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [BLK_W-1:0]   idx_ff, idx_in;
   logic [BLK_W-1:0]   s_ff, s_in;          // effective search start
   logic [WADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic               rd_wrap_ff, rd_wrap_in;
   logic [WCNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic               dv_ff, dv_in;
   logic [WADDR_W-1:0] d_addr_ff, d_addr_in;
   logic               d_wrap_ff, d_wrap_in;
   logic               ok_ff, ok_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [MAP_WORDS-1:0] word_vld_ff;

   logic [WCNT_W-1:0]  nwords;
   logic [WCNT_W-1:0]  total_reads;
   logic [WCNT_W-1:0]  size_w;
   logic [BIT_W-1:0]   size_b;
   logic [WADDR_W-1:0] s_w;
   logic [BIT_W-1:0]   s_b;
   logic [WADDR_W-1:0] sel_addr;
   word_type           word;
   word_type           vol_mask;
   word_type           pass_mask;
   word_type           cand;
   logic [BIT_W-1:0]   hit_pos;
   logic [BLK_W-1:0]   start;
   logic [BIT_W-1:0]   bit_sel;

   assign size_w      = cfg.size[SIZE_W-1:BIT_W];
   assign size_b      = cfg.size[BIT_W-1:0];
   assign nwords      = size_w + WCNT_W'(size_b != '0);
   assign total_reads = nwords + WCNT_W'(1);
   assign s_w         = s_ff[BLK_W-1:BIT_W];
   assign s_b         = s_ff[BIT_W-1:0];
   assign bit_sel     = idx_ff[BIT_W-1:0];

   // words never written read as all free
   assign sel_addr = (state_ff == ST_SCAN) ? d_addr_ff : idx_ff[BLK_W-1:BIT_W];
   assign word     = word_vld_ff[sel_addr] ? ram_rdata : '0;

   always_comb begin
      if ({1'b0, d_addr_ff} < size_w)       vol_mask = '1;
      else if ({1'b0, d_addr_ff} == size_w) vol_mask = mask_lt(size_b);
      else                                  vol_mask = '0;
      if (d_wrap_ff) begin
         if (d_addr_ff < s_w)       pass_mask = '1;
         else if (d_addr_ff == s_w) pass_mask = mask_lt(s_b);
         else                       pass_mask = '0;
      end else begin
         if (d_addr_ff > s_w)       pass_mask = '1;
         else if (d_addr_ff == s_w) pass_mask = ~mask_lt(s_b);
         else                       pass_mask = '0;
      end
      cand = ~word & vol_mask & pass_mask;
      if (d_addr_ff == '0) cand[0] = 1'b0;  // block zero is reserved
   end

   assign hit_pos = first_one(cand);

   // hint raised to one; a hint past the volume starts the scan at one
   always_comb begin
      start = (req_block_index == '0) ? BLK_W'(1) : req_block_index;
      if ({1'b0, start} >= cfg.size) start = BLK_W'(1);
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      s_in       = s_ff;
      rd_addr_in = rd_addr_ff;
      rd_wrap_in = rd_wrap_ff;
      rd_cnt_in  = rd_cnt_ff;
      dv_in      = 1'b0;
      d_addr_in  = d_addr_ff;
      d_wrap_in  = d_wrap_ff;
      ok_in      = ok_ff;
      blk_in     = blk_ff;
      ram_re     = 1'b0;
      ram_raddr  = rd_addr_ff;
      ram_we     = 1'b0;
      ram_waddr  = sel_addr;
      ram_wdata  = word;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in     = cmd_type'(req_cmd);
               idx_in     = req_block_index;
               s_in       = start;
               rd_addr_in = start[BLK_W-1:BIT_W];
               rd_wrap_in = 1'b0;
               rd_cnt_in  = '0;
               ok_in      = 1'b0;
               blk_in     = '0;
               if (cmd_type'(req_cmd) == CMD_ALLOC) begin
                  if (cfg.read_only || cfg.size < SIZE_W'(2)) state_in = ST_RESP;
                  else                                        state_in = ST_SCAN;
               end else if ({1'b0, req_block_index} >= cfg.size) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            ram_re    = 1'b1;
            ram_raddr = idx_ff[BLK_W-1:BIT_W];
            state_in  = ST_RMW;
         end
         ST_RMW: begin
            case (cmd_ff)
               CMD_MARK: begin
                  ram_we             = 1'b1;
                  ram_wdata[bit_sel] = 1'b1;
               end
               CMD_FREE: begin
                  ram_we             = 1'b1;
                  ram_wdata[bit_sel] = 1'b0;
               end
               CMD_QUERY: ok_in = word[bit_sel];
               default: ;
            endcase
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            // reads issue back to back; the word read in the previous cycle is checked
            if (rd_cnt_ff < total_reads) begin
               ram_re    = 1'b1;
               dv_in     = 1'b1;
               d_addr_in = rd_addr_ff;
               d_wrap_in = rd_wrap_ff;
               rd_cnt_in = rd_cnt_ff + WCNT_W'(1);
               if ({1'b0, rd_addr_ff} == nwords - WCNT_W'(1)) begin
                  rd_addr_in = '0;
                  rd_wrap_in = 1'b1;
               end else begin
                  rd_addr_in = rd_addr_ff + WADDR_W'(1);
               end
            end
            if (dv_ff) begin
               if (cand != '0) begin
                  ram_we             = 1'b1;
                  ram_wdata[hit_pos] = 1'b1;
                  ok_in              = 1'b1;
                  blk_in             = {d_addr_ff, hit_pos};
                  dv_in              = 1'b0;
                  state_in           = ST_RESP;
               end else if (rd_cnt_ff == total_reads) begin
                  dv_in    = 1'b0;
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (res_room) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign res.valid   = (state_ff == ST_RESP);
   assign res.success = ok_ff;
   assign res.block   = blk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         dv_ff       <= 1'b0;
         word_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= dv_in;
         if (ram_we) word_vld_ff[ram_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      s_ff       <= s_in;
      rd_addr_ff <= rd_addr_in;
      rd_wrap_ff <= rd_wrap_in;
      rd_cnt_ff  <= rd_cnt_in;
      d_addr_ff  <= d_addr_in;
      d_wrap_ff  <= d_wrap_in;
      ok_ff      <= ok_in;
      blk_ff     <= blk_in;
   end

   `HBBA_ASSERT(a_no_block_zero, clock, reset, (res.valid && res.success && cmd_ff == CMD_ALLOC) |-> (res.block != '0))
   `HBBA_ASSERT(a_we_states, clock, reset, ram_we |-> (state_ff == ST_SCAN || state_ff == ST_RMW))
   `HBBA_ASSERT(a_read_bound, clock, reset, (state_ff == ST_SCAN) |-> (rd_cnt_ff <= total_reads))
   `HBBA_ASSERT(a_idle_drained, clock, reset, (state_ff == ST_IDLE) |-> !dv_ff)
   `HBBA_ASSERT(a_one_hit_write, clock, reset, (ram_we && state_ff == ST_SCAN) |=> (state_ff == ST_RESP))

endmodule
